FILE: rtl/tga_rle_pixel_decoder_assert.svh
// Assertion macros shared by the TGA RLE pixel decoder modules.
// No dependencies; included by the files that carry assertions.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked while reset is low.
`define TGADEC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define TGADEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TGADEC_ASSERT(lbl, clk, rst, prop, msg)
`define TGADEC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/tgadec_pkg.sv
// Shared types and codes for the TGA RLE pixel decoder.
// No dependencies; used by the controller, datapath and top level.
package tgadec_pkg;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FORMAT  = 2'd1;
   localparam logic [1:0] ST_TRUNC   = 2'd2;
   localparam logic [1:0] ST_OVERRUN = 2'd3;

   // What the datapath loads into the result register
   localparam logic [1:0] EMIT_NONE = 2'd0;
   localparam logic [1:0] EMIT_FLAG = 2'd1;  // no pixels, status only
   localparam logic [1:0] EMIT_RAW  = 2'd2;  // one pixel from the byte just taken
   localparam logic [1:0] EMIT_RUN  = 2'd3;  // one or two pixels of the held run colour

   // Header byte positions
   localparam logic [4:0] HDR_ID_LEN = 5'd0;
   localparam logic [4:0] HDR_CMAP   = 5'd1;
   localparam logic [4:0] HDR_TYPE   = 5'd2;
   localparam logic [4:0] HDR_W_LO   = 5'd12;
   localparam logic [4:0] HDR_W_HI   = 5'd13;
   localparam logic [4:0] HDR_H_LO   = 5'd14;
   localparam logic [4:0] HDR_H_HI   = 5'd15;
   localparam logic [4:0] HDR_BPP    = 5'd16;
   localparam logic [4:0] HDR_DESC   = 5'd17;

   localparam logic [7:0] TYPE_RAW     = 8'd2;
   localparam logic [7:0] TYPE_RLE     = 8'd10;
   localparam logic [7:0] BPP_24       = 8'd24;
   localparam logic [7:0] BPP_32       = 8'd32;
   localparam int         DESC_TOP_BIT = 5;
   localparam int         PKT_RUN_BIT  = 7;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic       begin_data;
      logic       hdr_capture;
      logic [4:0] hdr_pos;
      logic       pix_clear;
      logic       pix_store;
      logic [1:0] byte_idx;
      logic       pix_final;
      logic       four;
      logic [1:0] emit_kind;
      logic [1:0] count;
      logic [1:0] status;
      logic       done;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic cur_last;   // current position is the image's final pixel
      logic next_last;  // position after one step is the final pixel
      logic empty;      // width or height is zero
      logic out_free;   // result register can take a beat this cycle
   } dp_status_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [31:0] first_address;
      logic [31:0] second_address;
      logic [1:0]  pixel_count;
      logic [1:0]  status;
      logic        image_done;
      logic        last_of_item;
   } rsp_beat_type;

endpackage

FILE: rtl/tgadec_req_if.sv
// Byte input channel of the TGA RLE pixel decoder.
// No dependencies.
interface tgadec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

FILE: rtl/tgadec_rsp_if.sv
// Pixel result channel of the TGA RLE pixel decoder.
// No dependencies.
interface tgadec_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic [31:0] first_address;
   logic [31:0] second_address;
   logic [1:0]  pixel_count;
   logic [1:0]  status;
   logic        image_done;
   logic        last_of_item;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output first_address, output second_address, output pixel_count,
                   output status, output image_done, output last_of_item, input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input first_address, input second_address, input pixel_count,
                   input status, input image_done, input last_of_item, output ready);
endinterface

FILE: rtl/tga_rle_pixel_decoder.sv
// Top level of the TGA true-color RLE pixel decoder.
// Depends on tgadec_pkg, tgadec_req_if, tgadec_rsp_if, tgadec_ctrl and tgadec_dp.
//
// Usage: req_chan takes the file one byte per beat from header byte 0;
//   end_of_file marks the final byte, the next beat starts a new file. rsp_chan
//   returns beats of zero, one or two RGBA pixels with their output addresses,
//   status, image_done and last_of_item.
// Results: a result caused by a byte shows in the cycle after that byte's beat.
//   A run's first beat is registered after its last color byte has latched
//   the run colour, then one beat per cycle while rsp_chan is ready:
//   ceil(n/2) beats for n pixels, at most 64, fewer if the image ends first.
// Throughput: one byte per cycle for header, ID, packet and raw pixel bytes
//   while results are taken, set by the single result register. After the last
//   color byte of a run, req_chan is held off until the run's beats are issued,
//   set by the two-pixel address stepper in the datapath.
// Reset: synchronous; the parser returns to header byte 0 and the result
//   register empties. No clearing pass is needed.
// Stall: while a result waits on rsp_chan.ready no byte is taken and run
//   emission pauses; nothing is lost or repeated.
module tga_rle_pixel_decoder (
   input logic          clock,
   input logic          reset,
   tgadec_req_if.sink   req_chan,
   tgadec_rsp_if.source rsp_chan
);
   import tgadec_pkg::*;

   dp_cmd_type    dp_cmd;     // controller -> datapath
   dp_status_type dp_status;  // datapath -> controller
   rsp_beat_type  rsp_beat;
   logic          rsp_valid;
   logic          req_ready;

   tgadec_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_ready),
      .data_byte   (req_chan.data_byte),
      .end_of_file (req_chan.end_of_file),
      .dp_status   (dp_status),
      .dp_cmd      (dp_cmd)
   );

   tgadec_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_chan.data_byte),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat)
   );

   assign req_chan.ready = req_ready;

   // result register straight to the port
   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.red            = rsp_beat.red;
   assign rsp_chan.green          = rsp_beat.green;
   assign rsp_chan.blue           = rsp_beat.blue;
   assign rsp_chan.alpha          = rsp_beat.alpha;
   assign rsp_chan.first_address  = rsp_beat.first_address;
   assign rsp_chan.second_address = rsp_beat.second_address;
   assign rsp_chan.pixel_count    = rsp_beat.pixel_count;
   assign rsp_chan.status         = rsp_beat.status;
   assign rsp_chan.image_done     = rsp_beat.image_done;
   assign rsp_chan.last_of_item   = rsp_beat.last_of_item;

endmodule

FILE: rtl/tgadec_ctrl.sv
// Parse controller: header, ID skip, packet and pixel sequencing, run emission.
// Depends on tgadec_pkg and tga_rle_pixel_decoder_assert.svh.
`include "tga_rle_pixel_decoder_assert.svh"
module tgadec_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               data_byte,
   input  logic                     end_of_file,
   input  tgadec_pkg::dp_status_type dp_status,
   output tgadec_pkg::dp_cmd_type    dp_cmd
);
   import tgadec_pkg::*;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_ID     = 3'd1;
   localparam logic [2:0] PH_PACKET = 3'd2;
   localparam logic [2:0] PH_PIXEL  = 3'd3;
   localparam logic [2:0] PH_RUN    = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;
   localparam logic [2:0] PH_ERROR  = 3'd6;

   logic [2:0] phase_ff, phase_in;
   logic [4:0] hdr_pos_ff, hdr_pos_in;
   logic [7:0] id_left_ff, id_left_in;
   logic       fault_ff, fault_in;
   logic       rle_ff, rle_in;
   logic       four_ff, four_in;
   logic [7:0] pkt_left_ff, pkt_left_in;
   logic       pkt_run_ff, pkt_run_in;
   logic [1:0] byte_idx_ff, byte_idx_in;
   logic       eof_ff, eof_in;

   logic       accept;
   logic       run_go;
   logic       begin_req;
   logic       defer_eof;
   logic       complete;
   logic       more;
   logic [7:0] pkt_dec;
   logic [7:0] rem;
   logic [1:0] last_idx;

   assign req_ready = dp_status.out_free && (phase_ff != PH_RUN);
   assign accept    = req_valid && req_ready;
   assign run_go    = (phase_ff == PH_RUN) && dp_status.out_free;
   assign last_idx  = four_ff ? 2'd3 : 2'd2;

   always_comb begin
      phase_in    = phase_ff;
      hdr_pos_in  = hdr_pos_ff;
      id_left_in  = id_left_ff;
      fault_in    = fault_ff;
      rle_in      = rle_ff;
      four_in     = four_ff;
      pkt_left_in = pkt_left_ff;
      pkt_run_in  = pkt_run_ff;
      byte_idx_in = byte_idx_ff;
      eof_in      = eof_ff;
      begin_req   = 1'b0;
      defer_eof   = 1'b0;
      complete    = 1'b0;
      more        = 1'b0;
      pkt_dec     = pkt_left_ff;
      rem         = '0;
      dp_cmd          = '0;
      dp_cmd.hdr_pos  = hdr_pos_ff;
      dp_cmd.byte_idx = byte_idx_ff;
      dp_cmd.four     = four_ff;

      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               dp_cmd.hdr_capture = 1'b1;
               case (hdr_pos_ff)
                  HDR_ID_LEN: id_left_in = data_byte;
                  HDR_CMAP: begin
                     if (data_byte != 8'd0) fault_in = 1'b1;
                  end
                  HDR_TYPE: begin
                     if (data_byte == TYPE_RAW) rle_in = 1'b0;
                     else if (data_byte == TYPE_RLE) rle_in = 1'b1;
                     else fault_in = 1'b1;
                  end
                  HDR_BPP: begin
                     if (data_byte == BPP_24) four_in = 1'b0;
                     else if (data_byte == BPP_32) four_in = 1'b1;
                     else fault_in = 1'b1;
                  end
                  default: ;
               endcase
               if (hdr_pos_ff == HDR_DESC) begin
                  hdr_pos_in = '0;
                  if (fault_ff) begin
                     dp_cmd.emit_kind = EMIT_FLAG;
                     dp_cmd.status    = ST_FORMAT;
                     dp_cmd.done      = 1'b1;
                     dp_cmd.last      = 1'b1;
                     phase_in         = PH_ERROR;
                  end else if (id_left_ff != 8'd0) begin
                     phase_in = PH_ID;
                  end else begin
                     begin_req = 1'b1;
                  end
               end else begin
                  hdr_pos_in = hdr_pos_ff + 5'd1;
               end
            end
            PH_ID: begin
               id_left_in = id_left_ff - 8'd1;
               if (id_left_ff == 8'd1) begin_req = 1'b1;
            end
            PH_PACKET: begin
               pkt_left_in      = {1'b0, data_byte[6:0]} + 8'd1;
               pkt_run_in       = data_byte[PKT_RUN_BIT];
               byte_idx_in      = '0;
               dp_cmd.pix_clear = 1'b1;
               phase_in         = PH_PIXEL;
            end
            PH_PIXEL: begin
               if (byte_idx_ff < last_idx) begin
                  dp_cmd.pix_store = 1'b1;
                  byte_idx_in      = byte_idx_ff + 2'd1;
               end else begin
                  byte_idx_in      = '0;
                  dp_cmd.pix_final = 1'b1;
                  if (rle_ff && pkt_run_ff) begin
                     // run colour latched; pixels go out from the run phase
                     phase_in  = PH_RUN;
                     eof_in    = end_of_file;
                     defer_eof = 1'b1;
                  end else begin
                     if (rle_ff && (pkt_left_ff != 8'd0)) pkt_dec = pkt_left_ff - 8'd1;
                     more             = rle_ff && (pkt_dec != 8'd0);
                     pkt_left_in      = pkt_dec;
                     complete         = dp_status.cur_last;
                     dp_cmd.emit_kind = EMIT_RAW;
                     dp_cmd.count     = 2'd1;
                     dp_cmd.last      = 1'b1;
                     if (complete) begin
                        dp_cmd.status = more ? ST_OVERRUN : ST_OK;
                        dp_cmd.done   = 1'b1;
                        phase_in      = more ? PH_ERROR : PH_DONE;
                        pkt_left_in   = '0;
                     end else if (rle_ff && !more) begin
                        phase_in = PH_PACKET;
                     end
                  end
               end
            end
            default: ;
         endcase

         if (begin_req) begin
            dp_cmd.begin_data = 1'b1;
            pkt_left_in       = '0;
            pkt_run_in        = 1'b0;
            byte_idx_in       = '0;
            if (dp_status.empty) begin
               dp_cmd.emit_kind = EMIT_FLAG;
               dp_cmd.status    = ST_OK;
               dp_cmd.done      = 1'b1;
               dp_cmd.last      = 1'b1;
               phase_in         = PH_DONE;
            end else begin
               phase_in = rle_ff ? PH_PACKET : PH_PIXEL;
            end
         end

         if (end_of_file && !defer_eof) begin
            if ((phase_in != PH_DONE) && (phase_in != PH_ERROR)) begin
               if (dp_cmd.emit_kind == EMIT_NONE) begin
                  dp_cmd.emit_kind = EMIT_FLAG;
                  dp_cmd.last      = 1'b1;
               end
               dp_cmd.status = ST_TRUNC;
               dp_cmd.done   = 1'b1;
            end
            phase_in    = PH_HEADER;
            hdr_pos_in  = '0;
            id_left_in  = '0;
            fault_in    = 1'b0;
            rle_in      = 1'b0;
            four_in     = 1'b0;
            pkt_left_in = '0;
            pkt_run_in  = 1'b0;
            byte_idx_in = '0;
         end
      end else if (run_go) begin
         // one or two run pixels per beat
         dp_cmd.emit_kind = EMIT_RUN;
         if ((pkt_left_ff > 8'd1) && !dp_status.cur_last) begin
            dp_cmd.count = 2'd2;
            complete     = dp_status.next_last;
            rem          = pkt_left_ff - 8'd2;
         end else begin
            dp_cmd.count = 2'd1;
            complete     = dp_status.cur_last;
            rem          = pkt_left_ff - 8'd1;
         end
         pkt_left_in = rem;
         if (complete) begin
            dp_cmd.status = (rem != 8'd0) ? ST_OVERRUN : ST_OK;
            dp_cmd.done   = 1'b1;
            dp_cmd.last   = 1'b1;
            phase_in      = (rem != 8'd0) ? PH_ERROR : PH_DONE;
            pkt_left_in   = '0;
         end else if (rem == 8'd0) begin
            dp_cmd.last = 1'b1;
            phase_in    = PH_PACKET;
         end
         if (dp_cmd.last && eof_ff) begin
            if (!complete) begin
               dp_cmd.status = ST_TRUNC;
               dp_cmd.done   = 1'b1;
            end
            eof_in      = 1'b0;
            phase_in    = PH_HEADER;
            hdr_pos_in  = '0;
            id_left_in  = '0;
            fault_in    = 1'b0;
            rle_in      = 1'b0;
            four_in     = 1'b0;
            pkt_left_in = '0;
            pkt_run_in  = 1'b0;
            byte_idx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_pos_ff  <= '0;
         id_left_ff  <= '0;
         fault_ff    <= 1'b0;
         rle_ff      <= 1'b0;
         four_ff     <= 1'b0;
         pkt_left_ff <= '0;
         pkt_run_ff  <= 1'b0;
         byte_idx_ff <= '0;
         eof_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         hdr_pos_ff  <= hdr_pos_in;
         id_left_ff  <= id_left_in;
         fault_ff    <= fault_in;
         rle_ff      <= rle_in;
         four_ff     <= four_in;
         pkt_left_ff <= pkt_left_in;
         pkt_run_ff  <= pkt_run_in;
         byte_idx_ff <= byte_idx_in;
         eof_ff      <= eof_in;
      end
   end

   `TGADEC_ASSERT(a_hdr_pos_idle, clock, reset, (phase_ff != PH_HEADER) |-> (hdr_pos_ff == 5'd0), "header position moved outside header phase")
   `TGADEC_ASSERT(a_run_nonempty, clock, reset, (phase_ff == PH_RUN) |-> (pkt_left_ff != 8'd0), "run phase with no pixels left")
   `TGADEC_ASSERT(a_idx_range, clock, reset, (byte_idx_ff == 2'd3) |-> four_ff, "fourth pixel byte in 24-bit mode")
   `TGADEC_ASSERT(a_emit_free, clock, reset, (dp_cmd.emit_kind != EMIT_NONE) |-> dp_status.out_free, "beat issued while result register busy")

endmodule

FILE: rtl/tgadec_dp.sv
// Datapath: header fields, pixel assembly, position/address counters, result register.
// Depends on tgadec_pkg and tga_rle_pixel_decoder_assert.svh.
`include "tga_rle_pixel_decoder_assert.svh"
module tgadec_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                data_byte,
   input  tgadec_pkg::dp_cmd_type    dp_cmd,
   output tgadec_pkg::dp_status_type dp_status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output tgadec_pkg::rsp_beat_type  rsp_beat
);
   import tgadec_pkg::*;

   typedef struct packed {
      logic [15:0] col;
      logic [15:0] row;
      logic [31:0] addr;
   } pos_type;

   // One pixel step; bottom-origin rows move back by two widths minus one at a wrap.
   function automatic pos_type step_pos(input pos_type p, input logic [15:0] w_last,
                                        input logic top, input logic [16:0] back);
      pos_type q;
      q = p;
      if (p.col == w_last) begin
         q.col  = '0;
         q.row  = p.row + 16'd1;
         q.addr = top ? (p.addr + 32'd1) : (p.addr - {15'd0, back});
      end else begin
         q.col  = p.col + 16'd1;
         q.addr = p.addr + 32'd1;
      end
      return q;
   endfunction

   logic [15:0]  width_ff, width_in;
   logic [15:0]  height_ff, height_in;
   logic         top_ff, top_in;
   logic [16:0]  back_ff, back_in;
   pos_type      pos_ff, pos_in;
   logic [23:0]  asm_ff, asm_in;
   logic [31:0]  color_ff, color_in;
   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff, beat_in;

   logic [15:0] w_last;
   logic [15:0] h_last;
   logic        top_now;
   logic [31:0] start_addr;
   logic [31:0] color_now;
   logic [31:0] beat_color;
   logic [1:0]  beat_count;
   pos_type     nxt;
   pos_type     nxt2;

   assign w_last     = width_ff - 16'd1;
   assign h_last     = height_ff - 16'd1;
   assign top_now    = (dp_cmd.hdr_capture && (dp_cmd.hdr_pos == HDR_DESC)) ?
                       data_byte[DESC_TOP_BIT] : top_ff;
   assign start_addr = 32'(h_last) * 32'(width_ff);
   assign nxt        = step_pos(pos_ff, w_last, top_ff, back_ff);
   assign nxt2       = step_pos(nxt, w_last, top_ff, back_ff);

   // BGR(A) byte order to RGBA
   assign color_now = dp_cmd.four ? {asm_ff[23:16], asm_ff[15:8], asm_ff[7:0], data_byte}
                                  : {data_byte, asm_ff[15:8], asm_ff[7:0], ALPHA_OPAQUE};

   assign dp_status.cur_last  = (pos_ff.col == w_last) && (pos_ff.row == h_last);
   assign dp_status.next_last = (nxt.col == w_last) && (nxt.row == h_last);
   assign dp_status.empty     = (width_ff == 16'd0) || (height_ff == 16'd0);
   assign dp_status.out_free  = !valid_ff || rsp_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      top_in    = top_ff;
      back_in   = back_ff;
      pos_in    = pos_ff;
      asm_in    = asm_ff;
      color_in  = color_ff;
      valid_in  = valid_ff && !rsp_ready;
      beat_in   = beat_ff;

      if (dp_cmd.hdr_capture) begin
         case (dp_cmd.hdr_pos)
            HDR_W_LO: width_in[7:0]   = data_byte;
            HDR_W_HI: width_in[15:8]  = data_byte;
            HDR_H_LO: height_in[7:0]  = data_byte;
            HDR_H_HI: height_in[15:8] = data_byte;
            HDR_DESC: top_in          = data_byte[DESC_TOP_BIT];
            default: ;
         endcase
      end

      if (dp_cmd.begin_data) begin
         pos_in.col  = '0;
         pos_in.row  = '0;
         pos_in.addr = top_now ? 32'd0 : start_addr;
         back_in     = {width_ff, 1'b0} - 17'd1;
         asm_in      = '0;
      end

      if (dp_cmd.pix_clear) asm_in = '0;
      if (dp_cmd.pix_store) begin
         case (dp_cmd.byte_idx)
            2'd0:    asm_in[7:0]   = data_byte;
            2'd1:    asm_in[15:8]  = data_byte;
            2'd2:    asm_in[23:16] = data_byte;
            default: ;
         endcase
      end
      if (dp_cmd.pix_final) begin
         asm_in   = '0;
         color_in = color_now;
      end

      case (dp_cmd.emit_kind)
         EMIT_RAW: begin
            beat_count = 2'd1;
            beat_color = color_now;
            pos_in     = nxt;
         end
         EMIT_RUN: begin
            beat_count = dp_cmd.count;
            beat_color = color_ff;
            pos_in     = (dp_cmd.count == 2'd2) ? nxt2 : nxt;
         end
         default: begin
            beat_count = 2'd0;
            beat_color = '0;
         end
      endcase

      if (dp_cmd.emit_kind != EMIT_NONE) begin
         valid_in               = 1'b1;
         beat_in.red            = beat_color[31:24];
         beat_in.green          = beat_color[23:16];
         beat_in.blue           = beat_color[15:8];
         beat_in.alpha          = beat_color[7:0];
         beat_in.first_address  = (beat_count != 2'd0) ? pos_ff.addr : 32'd0;
         beat_in.second_address = (beat_count == 2'd2) ? nxt.addr : 32'd0;
         beat_in.pixel_count    = beat_count;
         beat_in.status         = dp_cmd.status;
         beat_in.image_done     = dp_cmd.done;
         beat_in.last_of_item   = dp_cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff  <= width_in;
      height_ff <= height_in;
      top_ff    <= top_in;
      back_ff   <= back_in;
      pos_ff    <= pos_in;
      asm_ff    <= asm_in;
      color_ff  <= color_in;
      beat_ff   <= beat_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

   `TGADEC_ASSERT(a_emit_valid, clock, reset, (dp_cmd.emit_kind != EMIT_NONE) |=> valid_ff, "issued beat not presented")
   `TGADEC_ASSERT(a_empty_addr, clock, reset, (valid_ff && (beat_ff.pixel_count == 2'd0)) |-> ((beat_ff.first_address == 32'd0) && (beat_ff.red == 8'd0)), "pixel fields set on a status-only beat")
   `TGADEC_ASSERT(a_second_addr, clock, reset, (valid_ff && (beat_ff.pixel_count != 2'd2)) |-> (beat_ff.second_address == 32'd0), "second address set on a single-pixel beat")
   `TGADEC_ASSERT_ALWAYS(a_reset_valid, clock, $past(reset) |-> !valid_ff, "result valid after reset")

endmodule

FILE: dv/tb_tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// Testbench for tga_rle_pixel_decoder: streams whole TGA files one byte per beat and
// checks every pixel beat against an in-bench decoder model, field by field.
// Depends on tgadec_pkg, tgadec_req_if, tgadec_rsp_if and the decoder RTL.
module tb_tga_rle_pixel_decoder;
   import tgadec_pkg::*;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_BYTES = 130;
   localparam int SETTLE_WAIT  = 20;

   // Parser phases of the model; only this file uses them.
   typedef enum logic [2:0] {
      P_HEADER, P_ID, P_PACKET, P_PIXEL, P_DONE, P_ERROR
   } parse_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Local drivers, known from time zero.
   logic       src_valid  = 1'b0;
   logic [7:0] src_byte   = 8'd0;
   logic       src_eof    = 1'b0;
   logic       sink_ready = 1'b0;

   tgadec_req_if req_if();
   tgadec_rsp_if rsp_if();

   assign req_if.valid       = src_valid;
   assign req_if.data_byte   = src_byte;
   assign req_if.end_of_file = src_eof;
   assign rsp_if.ready       = sink_ready;

   tga_rle_pixel_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Run bookkeeping
   int send_idle_pct = 24;
   int recv_idle_pct = 46;
   int error_count   = 0;
   int cycle_count   = 0;
   int bytes_sent    = 0;

   logic [7:0]   byte_q[$];        // file under construction
   rsp_beat_type step_beats[$];    // beats caused by the byte being decoded
   rsp_beat_type pixels_due[$];    // predicted beats not yet seen

   // Append one predicted beat for the byte being decoded.
   task automatic queue_beat(input rsp_beat_type bt);
      step_beats.insert(step_beats.size(), bt);
   endtask

   // ---------------------------------------------------------------------------
   // Decoder model state
   // ---------------------------------------------------------------------------
   parse_phase_type m_phase;
   logic [4:0]   m_hdr_pos;
   logic [7:0]   m_id_left;
   logic         m_fault;
   logic         m_rle;
   logic         m_four;
   logic         m_top;
   logic [15:0]  m_width;
   logic [15:0]  m_height;
   logic [15:0]  m_col;
   logic [15:0]  m_row;
   logic [7:0]   m_pkt_left;
   logic         m_pkt_run;
   logic [23:0]  m_asm;
   logic [1:0]   m_byte_idx;

   task automatic clear_decoder();
      m_phase    = P_HEADER;
      m_hdr_pos  = 5'd0;
      m_id_left  = 8'd0;
      m_fault    = 1'b0;
      m_rle      = 1'b0;
      m_four     = 1'b0;
      m_top      = 1'b0;
      m_width    = 16'd0;
      m_height   = 16'd0;
      m_col      = 16'd0;
      m_row      = 16'd0;
      m_pkt_left = 8'd0;
      m_pkt_run  = 1'b0;
      m_asm      = 24'd0;
      m_byte_idx = 2'd0;
   endtask

   function automatic rsp_beat_type make_beat(logic [31:0] rgba, logic [31:0] addr_a,
                                              logic [31:0] addr_b, logic [1:0] cnt,
                                              logic [1:0] st, logic done);
      rsp_beat_type bt;
      bt.red            = rgba[31:24];
      bt.green          = rgba[23:16];
      bt.blue           = rgba[15:8];
      bt.alpha          = rgba[7:0];
      bt.first_address  = addr_a;
      bt.second_address = addr_b;
      bt.pixel_count    = cnt;
      bt.status         = st;
      bt.image_done     = done;
      bt.last_of_item   = 1'b0;
      return bt;
   endfunction

   // Output index of the current position; rows flip unless top origin.
   function automatic logic [31:0] pixel_address();
      logic [31:0] y;
      y = m_top ? {16'd0, m_row} : {16'd0, m_height} - 32'd1 - {16'd0, m_row};
      return y * {16'd0, m_width} + {16'd0, m_col};
   endfunction

   // Step one pixel; returns 1 once the last row is passed.
   function automatic logic step_position();
      m_col = m_col + 16'd1;
      if (m_col >= m_width) begin
         m_col = 16'd0;
         m_row = m_row + 16'd1;
      end
      return m_row >= m_height;
   endfunction

   task automatic start_pixel_data();
      m_col      = 16'd0;
      m_row      = 16'd0;
      m_pkt_left = 8'd0;
      m_pkt_run  = 1'b0;
      m_asm      = 24'd0;
      m_byte_idx = 2'd0;
      if (m_width == 16'd0 || m_height == 16'd0) begin
         // empty image finishes at once
         queue_beat(make_beat(32'd0, 32'd0, 32'd0, 2'd0, ST_OK, 1'b1));
         m_phase = P_DONE;
      end else begin
         m_phase = m_rle ? P_PACKET : P_PIXEL;
      end
   endtask

   task automatic take_pixel_byte(input logic [7:0] b);
      logic [1:0]  last_idx;
      logic [31:0] v;
      logic [31:0] rgba;
      logic [31:0] addr_a;
      logic [31:0] addr_b;
      logic [1:0]  cnt;
      logic        complete;
      logic        more;
      last_idx = m_four ? 2'd3 : 2'd2;
      v = {8'd0, m_asm};
      if (m_byte_idx < 2'd3)
         v = v | ({24'd0, b} << (8 * m_byte_idx));
      if (m_byte_idx < last_idx) begin
         m_asm      = v[23:0];
         m_byte_idx = m_byte_idx + 2'd1;
      end else begin
         m_asm      = 24'd0;
         m_byte_idx = 2'd0;
         // file order is B, G, R (, A)
         rgba = {v[23:16], v[15:8], v[7:0], m_four ? b : ALPHA_OPAQUE};
         if (m_rle && m_pkt_run) begin
            // run: two pixels per beat until the packet or the image runs out
            complete = 1'b0;
            while (m_pkt_left > 8'd0 && !complete) begin
               addr_a   = pixel_address();
               addr_b   = 32'd0;
               cnt      = 2'd1;
               complete = step_position();
               m_pkt_left = m_pkt_left - 8'd1;
               if (m_pkt_left > 8'd0 && !complete) begin
                  addr_b   = pixel_address();
                  complete = step_position();
                  m_pkt_left = m_pkt_left - 8'd1;
                  cnt      = 2'd2;
               end
               queue_beat(make_beat(rgba, addr_a, addr_b, cnt,
                  (complete && m_pkt_left > 8'd0) ? ST_OVERRUN : ST_OK, complete));
            end
            if (complete)
               m_phase = (m_pkt_left > 8'd0) ? P_ERROR : P_DONE;
            else
               m_phase = P_PACKET;
            m_pkt_left = 8'd0;
         end else begin
            addr_a   = pixel_address();
            complete = step_position();
            more     = 1'b0;
            if (m_rle) begin
               if (m_pkt_left > 8'd0)
                  m_pkt_left = m_pkt_left - 8'd1;
               more = m_pkt_left > 8'd0;
            end
            if (complete) begin
               queue_beat(make_beat(rgba, addr_a, 32'd0, 2'd1,
                                    more ? ST_OVERRUN : ST_OK, 1'b1));
               m_phase    = more ? P_ERROR : P_DONE;
               m_pkt_left = 8'd0;
            end else begin
               queue_beat(make_beat(rgba, addr_a, 32'd0, 2'd1, ST_OK, 1'b0));
               if (m_rle && !more)
                  m_phase = P_PACKET;
            end
         end
      end
   endtask

   // Model one accepted byte and queue the beats it causes.
   task automatic decode_byte(input logic [7:0] b, input logic eof);
      step_beats.delete();
      case (m_phase)
         P_HEADER: begin
            case (m_hdr_pos)
               HDR_ID_LEN: m_id_left = b;
               HDR_CMAP:   if (b != 8'd0) m_fault = 1'b1;
               HDR_TYPE: begin
                  if (b == TYPE_RAW)      m_rle = 1'b0;
                  else if (b == TYPE_RLE) m_rle = 1'b1;
                  else                    m_fault = 1'b1;
               end
               HDR_W_LO:   m_width[7:0]   = b;
               HDR_W_HI:   m_width[15:8]  = b;
               HDR_H_LO:   m_height[7:0]  = b;
               HDR_H_HI:   m_height[15:8] = b;
               HDR_BPP: begin
                  if (b == BPP_24)      m_four = 1'b0;
                  else if (b == BPP_32) m_four = 1'b1;
                  else                  m_fault = 1'b1;
               end
               HDR_DESC:   m_top = b[DESC_TOP_BIT];
               default: ;
            endcase
            if (m_hdr_pos >= HDR_DESC) begin
               m_hdr_pos = 5'd0;
               if (m_fault) begin
                  queue_beat(make_beat(32'd0, 32'd0, 32'd0, 2'd0, ST_FORMAT, 1'b1));
                  m_phase = P_ERROR;
               end else if (m_id_left > 8'd0) begin
                  m_phase = P_ID;
               end else begin
                  start_pixel_data();
               end
            end else begin
               m_hdr_pos = m_hdr_pos + 5'd1;
            end
         end
         P_ID: begin
            m_id_left = m_id_left - 8'd1;
            if (m_id_left == 8'd0)
               start_pixel_data();
         end
         P_PACKET: begin
            m_pkt_left = {1'b0, b[6:0]} + 8'd1;
            m_pkt_run  = b[PKT_RUN_BIT];
            m_asm      = 24'd0;
            m_byte_idx = 2'd0;
            m_phase    = P_PIXEL;
         end
         P_PIXEL: take_pixel_byte(b);
         default: ;
      endcase

      if (eof) begin
         // short file: flag it on the last beat, or on a beat of its own
         if (m_phase != P_DONE && m_phase != P_ERROR) begin
            if (step_beats.size() > 0) begin
               step_beats[step_beats.size() - 1].status     = ST_TRUNC;
               step_beats[step_beats.size() - 1].image_done = 1'b1;
            end else begin
               queue_beat(make_beat(32'd0, 32'd0, 32'd0, 2'd0, ST_TRUNC, 1'b1));
            end
         end
         clear_decoder();
      end
      if (step_beats.size() > 0)
         step_beats[step_beats.size() - 1].last_of_item = 1'b1;
      foreach (step_beats[i])
         pixels_due.insert(pixels_due.size(), step_beats[i]);
   endtask

   // ---------------------------------------------------------------------------
   // Clock, run limit, receiver and checker
   // ---------------------------------------------------------------------------
   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, pixels_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Sink backpressure changes on the falling edge.
   always @(negedge clock) begin
      sink_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Every rsp beat is matched against the oldest prediction.
   always @(posedge clock) begin
      rsp_beat_type seen;
      rsp_beat_type want;
      if (!reset && rsp_if.valid === 1'b1 && sink_ready) begin
         seen.red            = rsp_if.red;
         seen.green          = rsp_if.green;
         seen.blue           = rsp_if.blue;
         seen.alpha          = rsp_if.alpha;
         seen.first_address  = rsp_if.first_address;
         seen.second_address = rsp_if.second_address;
         seen.pixel_count    = rsp_if.pixel_count;
         seen.status         = rsp_if.status;
         seen.image_done     = rsp_if.image_done;
         seen.last_of_item   = rsp_if.last_of_item;
         if (pixels_due.size() == 0) begin
            $display("%0t: unexpected beat, expected none actual 0x%0h", $time, seen);
            error_count++;
         end else begin
            want = pixels_due.pop_front();
            check_field("red",            {24'd0, want.red},         {24'd0, seen.red});
            check_field("green",          {24'd0, want.green},       {24'd0, seen.green});
            check_field("blue",           {24'd0, want.blue},        {24'd0, seen.blue});
            check_field("alpha",          {24'd0, want.alpha},       {24'd0, seen.alpha});
            check_field("first_address",  want.first_address,        seen.first_address);
            check_field("second_address", want.second_address,       seen.second_address);
            check_field("pixel_count",    {30'd0, want.pixel_count}, {30'd0, seen.pixel_count});
            check_field("status",         {30'd0, want.status},      {30'd0, seen.status});
            check_field("image_done",     {31'd0, want.image_done},  {31'd0, seen.image_done});
            check_field("last_of_item",   {31'd0, want.last_of_item},
                        {31'd0, seen.last_of_item});
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Byte source
   // ---------------------------------------------------------------------------
   // One byte beat; random gaps before it, driven on the falling edge.
   task automatic send_byte(input logic [7:0] b, input logic eof);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         src_valid <= 1'b0;
         @(negedge clock);
      end
      src_valid <= 1'b1;
      src_byte  <= b;
      src_eof   <= eof;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      decode_byte(b, eof);
      bytes_sent++;
   endtask

   // Hold the source off until every predicted beat has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      src_valid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
   endtask

   // Send the built file; end_of_file rides on its last byte.
   task automatic send_file();
      for (int i = 0; i < byte_q.size(); i++)
         send_byte(byte_q[i], i == byte_q.size() - 1);
      byte_q.delete();
   endtask

   // ---------------------------------------------------------------------------
   // File builders
   // ---------------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] b);
      byte_q.insert(byte_q.size(), b);
   endtask

   task automatic add_random_bytes(input int n);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
   endtask

   // 18-byte header; color-map spec and origin words are filler.
   task automatic add_header(input logic [7:0] id_len, input logic [7:0] cmap,
                             input logic [7:0] img_type, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] bpp, input logic top);
      logic [7:0] desc;
      add_byte(id_len);
      add_byte(cmap);
      add_byte(img_type);
      add_random_bytes(9);
      add_byte(w[7:0]);
      add_byte(w[15:8]);
      add_byte(h[7:0]);
      add_byte(h[15:8]);
      add_byte(bpp);
      desc = 8'($urandom_range(0, 255));
      desc[DESC_TOP_BIT] = top;
      add_byte(desc);
   endtask

   task automatic add_raw_data(input int n, input logic four);
      add_random_bytes(n * (four ? 4 : 3));
   endtask

   // Packets covering total pixels; with overrun_ok a packet may reach past the end.
   task automatic add_rle_data(input int total, input logic four, input logic overrun_ok);
      int   left;
      int   cnt;
      logic run;
      left = total;
      while (left > 0) begin
         cnt = $urandom_range(1, (left < 128) ? left : 128);
         run = 1'($urandom_range(0, 1));
         if (overrun_ok && $urandom_range(0, 3) == 0)
            cnt = run ? $urandom_range(cnt, 128) : ((cnt + 3 > 128) ? 128 : cnt + 3);
         add_byte({run, 7'(cnt - 1)});
         add_raw_data(run ? 1 : cnt, four);
         left -= cnt;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   task automatic test_bad_format();
      // nonzero color-map type, eof on the descriptor byte
      add_header(8'd0, 8'h01, TYPE_RAW, 16'd2, 16'd2, BPP_24, 1'b0);
      send_file();
      // bad type and depth, longest ID length, trailing bytes ignored
      add_header(8'hFF, 8'h00, 8'h03, 16'd1, 16'd1, 8'h10, 1'b1);
      add_random_bytes(2);
      send_file();
   endtask

   task automatic test_empty_image();
      // zero width, completes on the last ID byte
      add_header(8'd2, 8'h00, TYPE_RLE, 16'd0, 16'd3, BPP_32, 1'b1);
      add_random_bytes(2);
      send_file();
      // zero height, completes on the descriptor, then junk
      add_header(8'd0, 8'h00, TYPE_RAW, 16'd4, 16'd0, BPP_24, 1'b0);
      add_random_bytes(1);
      send_file();
   endtask

   task automatic test_truncation();
      // eof inside the header
      add_random_bytes(5);
      send_file();
      // eof inside a 255-byte ID field
      add_header(8'hFF, 8'h00, TYPE_RAW, 16'd2, 16'd2, BPP_24, 1'b0);
      add_random_bytes(4);
      send_file();
      // eof on a byte that also finishes a pixel
      add_header(8'd0, 8'h00, TYPE_RAW, 16'd2, 16'd2, BPP_24, 1'b0);
      add_raw_data(2, 1'b0);
      send_file();
      wait_for_drain();
   endtask

   task automatic test_run_overrun();
      // run of 5 into a 2x2 image
      add_header(8'd0, 8'h00, TYPE_RLE, 16'd2, 16'd2, BPP_32, 1'b1);
      add_byte({1'b1, 7'd4});
      add_raw_data(1, 1'b1);
      add_random_bytes(2);
      send_file();
      // raw packet of 2 into a 1x1 image
      add_header(8'd0, 8'h00, TYPE_RLE, 16'd1, 16'd1, BPP_24, 1'b0);
      add_byte({1'b0, 7'd1});
      add_raw_data(2, 1'b0);
      send_file();
   endtask

   task automatic test_raw_image();
      add_header(8'd1, 8'h00, TYPE_RAW, 16'd2, 16'd2, BPP_32, 1'b0);
      add_random_bytes(1);
      add_raw_data(4, 1'b1);
      add_random_bytes(1);
      send_file();
   endtask

   task automatic test_address_extremes();
      // largest image, bottom origin: addresses near the top of the range;
      // a 128-pixel run fills 64 beats, then eof on the next packet byte
      add_header(8'd0, 8'h00, TYPE_RLE, 16'hFFFF, 16'hFFFF, BPP_24, 1'b0);
      add_byte(8'hFF);
      add_byte(8'hFF);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(8'h00);
      send_file();
      wait_for_drain();
   endtask

   // Mostly well-formed files with random content, some noise and cut-offs.
   task automatic random_file();
      int   kind;
      int   w;
      int   h;
      int   id_len;
      int   cut;
      logic rle;
      logic four;
      logic top;
      logic [7:0] cmap;
      logic [7:0] img_type;
      logic [7:0] bpp;
      kind   = $urandom_range(0, 99);
      rle    = 1'($urandom_range(0, 1));
      four   = 1'($urandom_range(0, 1));
      top    = 1'($urandom_range(0, 1));
      id_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      if (kind < 10) begin
         // wide RLE image: long runs, many beats per byte
         w   = $urandom_range(20, 130);
         h   = $urandom_range(1, 2);
         rle = 1'b1;
      end else begin
         w = $urandom_range(1, 5);
         h = $urandom_range(1, 3);
      end
      if ($urandom_range(0, 19) == 0)
         w = 0;
      else if ($urandom_range(0, 19) == 0)
         h = 0;

      if (kind >= 10 && kind < 18) begin
         // noise: format fields mostly out of range
         cmap     = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
         img_type = ($urandom_range(0, 2) == 0) ? TYPE_RLE : 8'($urandom_range(0, 255));
         bpp      = ($urandom_range(0, 2) == 0) ? BPP_32 : 8'($urandom_range(0, 255));
         add_header(8'(id_len), cmap, img_type, 16'(w), 16'(h), bpp, top);
         add_random_bytes($urandom_range(0, 6));
      end else begin
         add_header(8'(id_len), 8'h00, rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h),
                    four ? BPP_32 : BPP_24, top);
         add_random_bytes(id_len);
         if (rle)
            add_rle_data(w * h, four, $urandom_range(0, 5) == 0);
         else
            add_raw_data(w * h, four);
         if ($urandom_range(0, 5) == 0)
            add_random_bytes($urandom_range(1, 4));
         if (kind >= 18 && kind < 32 && byte_q.size() > 1) begin
            cut = $urandom_range(1, byte_q.size() - 1);
            while (byte_q.size() > cut) void'(byte_q.pop_back());
         end
      end
      send_file();
   endtask

   task automatic test_random_files();
      int start;
      start = bytes_sent;
      for (int ph = 0; ph < 3; ph++) begin
         // idle mix: source-light, then sink-light, then none
         case (ph)
            0: begin send_idle_pct = 24; recv_idle_pct = 46; end
            1: begin send_idle_pct = 46; recv_idle_pct = 24; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         while (bytes_sent - start < RANDOM_BYTES * (ph + 1) / 3)
            random_file();
         wait_for_drain();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      clear_decoder();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bad_format();
      test_empty_image();
      test_truncation();
      test_run_overrun();
      test_raw_image();
      test_address_extremes();
      test_random_files();

      wait_for_drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
